// ===== sv/aed_pkg.sv =====
package aed_pkg;

    // Defaults and fixed limits
    localparam int MAX_SLICE_WIDTH_DEF = 256;
    localparam int MAX_SLICE_HEIGHT    = 256;

    // Register and field widths
    localparam int DIM_W     = 9;
    localparam int ROW_W     = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_HEIGHT = 8'd1;

    localparam logic [7:0] DILATED_ALPHA = 8'd96;

    // Eight neighbours of 8 bits at most
    localparam int SUM_W = 11;
    localparam int CNT_W = 4;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic shift;
        logic sum;
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bottom_ok;
    } t_win_ctrl;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] count;
        t_pixel           centre;
    } t_sums;

endpackage

// ===== sv/aed_line_store.sv =====
module aed_line_store
    import aed_pkg::*;
#(
    parameter int   DEPTH = 2 * MAX_SLICE_WIDTH_DEF + 2,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pixel        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_pixel        o_rdata_a,
    output t_pixel        o_rdata_b
);

    t_pixel r_mem [DEPTH];
    t_pixel r_rdata_a;
    t_pixel r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== sv/aed_window.sv =====
module aed_window
    import aed_pkg::*;
(
    input  logic      i_clk,
    input  t_win_ctrl i_ctrl,
    input  t_pixel    i_top,
    input  t_pixel    i_mid,
    input  t_pixel    i_bot,
    output t_sums     o_sums
);

    t_pixel     r_win [9];
    t_sums      r_sums;
    t_sums      n_sums;
    logic [8:0] in_frame;

    // Opaque in-frame neighbours only; the centre never counts
    always_comb begin
        n_sums        = '0;
        n_sums.centre = r_win[4];
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                in_frame[row*3+col] = (row != 0 || i_ctrl.top_ok)
                                   && (row != 2 || i_ctrl.bottom_ok)
                                   && (col != 0 || i_ctrl.left_ok)
                                   && (col != 2 || i_ctrl.right_ok);
            end
        end
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && in_frame[k] && r_win[k].alpha != 8'd0) begin
                n_sums.red   = n_sums.red   + SUM_W'(r_win[k].red);
                n_sums.green = n_sums.green + SUM_W'(r_win[k].green);
                n_sums.blue  = n_sums.blue  + SUM_W'(r_win[k].blue);
                n_sums.count = n_sums.count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            for (int row = 0; row < 3; row++) begin
                r_win[row*3]   <= r_win[row*3+1];
                r_win[row*3+1] <= r_win[row*3+2];
            end
            r_win[2] <= i_top;
            r_win[5] <= i_mid;
            r_win[8] <= i_bot;
        end
        if (i_ctrl.sum) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

// ===== sv/aed_mean.sv =====
module aed_mean
    import aed_pkg::*;
(
    input  t_sums  i_sums,
    output t_pixel o_pixel
);

    localparam int RECIP_SHIFT = 15;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // ceil(2^15 / n): exact truncated quotient for sums below 2^15 / 7
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd5:    m = 16'd6554;
            4'd6:    m = 16'd5462;
            4'd7:    m = 16'd4682;
            4'd8:    m = 16'd4096;
            default: m = '0;
        endcase
        return m;
    endfunction

    logic [RECIP_W-1:0] factor;
    logic [PROD_W-1:0]  prod_r;
    logic [PROD_W-1:0]  prod_g;
    logic [PROD_W-1:0]  prod_b;

    assign factor = recip(i_sums.count);
    assign prod_r = PROD_W'(i_sums.red)   * PROD_W'(factor);
    assign prod_g = PROD_W'(i_sums.green) * PROD_W'(factor);
    assign prod_b = PROD_W'(i_sums.blue)  * PROD_W'(factor);

    always_comb begin
        if (i_sums.centre.alpha != 8'd0 || i_sums.count == '0) begin
            o_pixel = i_sums.centre;
        end else begin
            o_pixel.red   = prod_r[RECIP_SHIFT +: 8];
            o_pixel.green = prod_g[RECIP_SHIFT +: 8];
            o_pixel.blue  = prod_b[RECIP_SHIFT +: 8];
            o_pixel.alpha = DILATED_ALPHA;
        end
    end

endmodule

// ===== sv/alpha_edge_dilation_3x3.sv =====
// One-texel alpha edge dilation over a 3x3 window. Pixels of a slice enter in
// raster order, followed by slice_width+1 drain transfers; each pixel leaves
// once its full neighbourhood has arrived, i.e. slice_width+1 transfers later.
// Opaque pixels pass unchanged; a transparent pixel takes the truncated mean
// RGB of its opaque in-slice neighbours with alpha 96, or passes unchanged if
// it has none. The last pixel of the slice carries o_frame_end, after which a
// new slice starts. A drain transfer while pixels are still expected is
// dropped; a pixel transfer after the slice is complete counts as drain.
// Each transfer is accepted, then the two-port line store read returns and
// the store is written back; one that yields a result then passes two more
// stages, the window sum and the reciprocal multiply, and waits while the
// output register is held by i_stall. The input stalls until a transfer is
// through. The line store holds the last 2*width+2 transfers and needs no
// clearing after reset: only entries already written in this slice are used.
// Writing slice_width or slice_height restarts the slice and must only be
// done while the block is idle; both are clamped to 1..MAX_SLICE_WIDTH and
// 1..256 respectively.
module alpha_edge_dilation_3x3
    import aed_pkg::*;
#(
    parameter int MAX_SLICE_WIDTH = MAX_SLICE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_in_red,
    input  logic [7:0]           i_in_green,
    input  logic [7:0]           i_in_blue,
    input  logic [7:0]           i_in_alpha,
    input  logic                 i_drain,
    // pixel output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_red,
    output logic [7:0]           o_out_green,
    output logic [7:0]           o_out_blue,
    output logic [7:0]           o_out_alpha,
    output logic                 o_frame_end,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int WW    = $clog2(MAX_SLICE_WIDTH + 1);  // width value
    localparam int XW    = $clog2(MAX_SLICE_WIDTH);      // column index
    localparam int LW    = $clog2(MAX_SLICE_WIDTH + 2);  // lead-in count
    localparam int DEPTH = 2 * MAX_SLICE_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (WW > DIM_W) ? WW : DIM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_SUM,
        S_MEAN
    } t_state;

    t_state n_state;
    t_state r_state;

    // Configuration
    logic [DIM_W-1:0] r_slice_width;
    logic [DIM_W-1:0] r_slice_height;

    // Positions
    logic [AW-1:0]    r_wa;        // store slot of the current transfer
    logic [LW-1:0]    r_lead;      // transfers taken, saturating at width+1
    logic [XW-1:0]    r_in_x;
    logic [ROW_W-1:0] r_in_y;
    logic             r_in_done;
    logic [XW-1:0]    r_out_x;
    logic [ROW_W-1:0] r_out_y;

    // Transfer being worked on
    t_pixel r_cur;
    logic   r_drain;
    logic   r_left_ok;
    logic   r_right_ok;
    logic   r_top_ok;
    logic   r_bottom_ok;
    logic   r_fe;

    // Output register
    t_pixel r_out;
    logic   r_out_fe;
    logic   r_out_valid;

    // Effective dimensions
    logic [CW-1:0]    width_raw;
    logic [CW-1:0]    width_wide;
    logic [WW-1:0]    w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [XW-1:0]    w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [LW-1:0]    lead_full;

    // Ring addressing
    logic [AW-1:0] ring_last;
    logic [AW:0]   ring_size;
    logic [AW:0]   sum_a;
    logic [AW:0]   sum_b;
    logic [AW-1:0] ra_a;
    logic [AW-1:0] ra_b;
    logic [AW-1:0] wa_next;

    // Control
    logic      in_xfer;
    logic      cfg_write;
    logic      cfg_hit;
    logic      ignore;
    logic      is_pixel;
    logic      emit;
    logic      frame_last;
    logic      out_free;
    logic      store_we;
    logic      restart;
    t_win_ctrl win_ctrl;
    t_pixel    rd_top;
    t_pixel    rd_mid;
    t_sums     sums;
    t_pixel    mean_px;

    // Clamp width to 1..MAX and height to 1..256
    assign width_raw = CW'(r_slice_width);
    always_comb begin
        if (width_raw == '0) begin
            width_wide = CW'(1);
        end else if (width_raw > CW'(MAX_SLICE_WIDTH)) begin
            width_wide = CW'(MAX_SLICE_WIDTH);
        end else begin
            width_wide = width_raw;
        end
        if (r_slice_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_slice_height > DIM_W'(MAX_SLICE_HEIGHT)) begin
            h_eff = DIM_W'(MAX_SLICE_HEIGHT);
        end else begin
            h_eff = r_slice_height;
        end
    end

    assign w_eff     = WW'(width_wide);
    assign w_m1      = XW'(w_eff - WW'(1));
    assign h_m1      = ROW_W'(h_eff - DIM_W'(1));
    assign lead_full = LW'(w_eff) + LW'(1);

    // Ring of 2w+2 slots: the row above sits w slots back, two rows above 2w
    assign ring_last = AW'({w_eff, 1'b1});
    assign ring_size = (AW + 1)'(ring_last) + (AW + 1)'(1);
    assign sum_a     = (AW + 1)'(r_wa) + (AW + 1)'(2);
    assign sum_b     = (AW + 1)'(r_wa) + (AW + 1)'(w_eff) + (AW + 1)'(2);
    assign ra_a      = (sum_a >= ring_size) ? AW'(sum_a - ring_size) : AW'(sum_a);
    assign ra_b      = (sum_b >= ring_size) ? AW'(sum_b - ring_size) : AW'(sum_b);
    assign wa_next   = (r_wa == ring_last) ? '0 : r_wa + AW'(1);

    assign in_xfer    = i_valid && !o_stall;
    assign cfg_write  = i_cfg_valid && o_cfg_ready;
    assign cfg_hit    = (i_cfg_index == REG_SLICE_WIDTH) || (i_cfg_index == REG_SLICE_HEIGHT);
    assign is_pixel   = !r_in_done;
    assign ignore     = is_pixel && r_drain;
    assign emit       = (r_lead == lead_full);
    assign frame_last = (r_out_x == w_m1) && (r_out_y == h_m1);
    assign out_free   = !r_out_valid || !i_stall;
    assign store_we   = (r_state == S_GATHER) && !ignore && is_pixel;
    assign restart    = (cfg_write && cfg_hit)
                     || ((r_state == S_GATHER) && !ignore && emit && frame_last);

    assign win_ctrl.shift     = (r_state == S_GATHER) && !ignore;
    assign win_ctrl.sum       = (r_state == S_SUM);
    assign win_ctrl.left_ok   = r_left_ok;
    assign win_ctrl.right_ok  = r_right_ok;
    assign win_ctrl.top_ok    = r_top_ok;
    assign win_ctrl.bottom_ok = r_bottom_ok;

    aed_line_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   (r_wa),
        .i_wdata   (r_cur),
        .i_re      (in_xfer),
        .i_raddr_a (ra_a),
        .i_raddr_b (ra_b),
        .o_rdata_a (rd_top),
        .o_rdata_b (rd_mid)
    );

    aed_window u_window (
        .i_clk  (i_clk),
        .i_ctrl (win_ctrl),
        .i_top  (rd_top),
        .i_mid  (rd_mid),
        .i_bot  (r_cur),
        .o_sums (sums)
    );

    aed_mean u_mean (
        .i_sums  (sums),
        .o_pixel (mean_px)
    );

    always_comb begin
        case (r_state)
            S_IDLE:   n_state = in_xfer ? S_GATHER : S_IDLE;
            S_GATHER: n_state = (!ignore && emit) ? S_SUM : S_IDLE;
            S_SUM:    n_state = S_MEAN;
            S_MEAN:   n_state = out_free ? S_IDLE : S_MEAN;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slice_width  <= DIM_RESET;
            r_slice_height <= DIM_RESET;
            r_wa           <= '0;
            r_lead         <= '0;
            r_in_x         <= '0;
            r_in_y         <= '0;
            r_in_done      <= 1'b0;
            r_out_x        <= '0;
            r_out_y        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // load wins over the drain of the old result
            if ((r_state == S_MEAN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_write) begin
                case (i_cfg_index)
                    REG_SLICE_WIDTH:  r_slice_width  <= i_cfg_data;
                    REG_SLICE_HEIGHT: r_slice_height <= i_cfg_data;
                    default:          ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cur   <= '{alpha: i_in_alpha, blue: i_in_blue,
                                     green: i_in_green, red: i_in_red};
                        r_drain <= i_drain;
                    end
                end
                S_GATHER: begin
                    if (!ignore) begin
                        if (emit) begin
                            // borders of the pixel about to be emitted
                            r_left_ok   <= (r_out_x != '0);
                            r_right_ok  <= (r_out_x != w_m1);
                            r_top_ok    <= (r_out_y != '0);
                            r_bottom_ok <= (r_out_y != h_m1);
                            r_fe        <= frame_last;
                        end
                        // last pixel of the slice: positions cleared below
                        if (!restart) begin
                            r_wa <= wa_next;
                            if (!emit) begin
                                r_lead <= r_lead + LW'(1);
                            end
                            if (is_pixel) begin
                                if (r_in_x == w_m1) begin
                                    r_in_x <= '0;
                                    if (r_in_y == h_m1) begin
                                        r_in_done <= 1'b1;
                                    end else begin
                                        r_in_y <= r_in_y + ROW_W'(1);
                                    end
                                end else begin
                                    r_in_x <= r_in_x + XW'(1);
                                end
                            end
                            if (emit) begin
                                if (r_out_x == w_m1) begin
                                    r_out_x <= '0;
                                    r_out_y <= r_out_y + ROW_W'(1);
                                end else begin
                                    r_out_x <= r_out_x + XW'(1);
                                end
                            end
                        end
                    end
                end
                S_SUM: ;
                S_MEAN: begin
                    if (out_free) begin
                        r_out    <= mean_px;
                        r_out_fe <= r_fe;
                    end
                end
                default: ;
            endcase

            // new slice: after the last pixel or on a register write
            if (restart) begin
                r_wa      <= '0;
                r_lead    <= '0;
                r_in_x    <= '0;
                r_in_y    <= '0;
                r_in_done <= 1'b0;
                r_out_x   <= '0;
                r_out_y   <= '0;
            end
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out.red;
    assign o_out_green = r_out.green;
    assign o_out_blue  = r_out.blue;
    assign o_out_alpha = r_out.alpha;
    assign o_frame_end = r_out_fe;

endmodule

// ===== dv/testbench.sv =====
module testbench
    import aed_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Ring of the last 2*width+2 transfers, at the largest width
    localparam int STORE_DEPTH    = 2 * MAX_SLICE_WIDTH_DEF + 2;
    // Quiet cycles before the run is declared hung. The longest legal gap is
    // the deliberate receiver hold, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    // Covers anything still in flight once the result queue is empty.
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;

    // One expected output pixel
    typedef struct {
        t_pixel pix;
        logic   frame_end;
    } t_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_in_red    = '0;
    logic [7:0]           i_in_green  = '0;
    logic [7:0]           i_in_blue   = '0;
    logic [7:0]           i_in_alpha  = '0;
    logic                 i_drain     = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [7:0]           o_out_red;
    logic [7:0]           o_out_green;
    logic [7:0]           o_out_blue;
    logic [7:0]           o_out_alpha;
    logic                 o_frame_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SLICE_WIDTH;
    logic [DIM_W-1:0]     i_cfg_data  = '0;

    always #5 i_clk = ~i_clk;

    alpha_edge_dilation_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .i_drain     (i_drain),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers, the line store and
    // the two slice positions. Positions wrap at 17 and 16 bits.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg  = DIM_RESET;
    logic [DIM_W-1:0] height_reg = DIM_RESET;
    t_pixel           store_mem [STORE_DEPTH];
    logic [16:0]      in_count   = '0;
    logic [15:0]      out_count  = '0;
    t_result          expected_pixels [$];

    // Traffic shaping, set per test
    int send_gap_pct  = 0;
    int rx_stall_pct  = 0;
    int hold_asked    = 0;   // bumped by a test to request a long hold
    int hold_seen     = 0;   // receiver's own copy
    int hold_left     = 0;

    int errors        = 0;
    int items_taken   = 0;   // transfers that the block did not drop
    int quiet_cycles  = 0;

    // Out-of-range sizes: 0 acts as 1, anything above the limit as the limit
    function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
        if (v == '0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic t_pixel make_pixel(int r, int g, int b, int a);
        t_pixel px;
        px.red   = 8'(r);
        px.green = 8'(g);
        px.blue  = 8'(b);
        px.alpha = 8'(a);
        return px;
    endfunction

    function automatic t_pixel random_pixel(int opaque_pct);
        t_pixel px;
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        px.alpha = ($urandom_range(99) < opaque_pct) ? 8'($urandom_range(255, 1)) : 8'd0;
        return px;
    endfunction

    // Works out the effect of one accepted transfer. Pixel p leaves when
    // transfer p+width+1 arrives; a transparent centre takes the truncated
    // mean of its opaque in-slice neighbours. Returns 0 for a dropped drain.
    function automatic bit predict_dilation(t_pixel cur, logic drain);
        int      w, h, total, ring, q, p, x, y, n, cnt;
        int      sum_r, sum_g, sum_b;
        bit      emit;
        t_pixel  nb;
        t_result res;
        w     = clamp_dim(width_reg, MAX_SLICE_WIDTH_DEF);
        h     = clamp_dim(height_reg, MAX_SLICE_HEIGHT);
        total = w * h;
        ring  = 2 * w + 2;
        q     = int'(in_count);
        emit  = q >= w + 1;
        // drain flag while pixels are still due: dropped outright
        if (q < total && drain)
            return 1'b0;
        if (emit) begin
            p = int'(out_count);
            x = p % w;
            y = p / w;
            res.pix = store_mem[p % ring];
            if (res.pix.alpha == 8'd0) begin
                sum_r = 0;
                sum_g = 0;
                sum_b = 0;
                cnt   = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if (x + dx >= 0 && x + dx < w && y + dy >= 0 && y + dy < h) begin
                            n  = (y + dy) * w + x + dx;
                            nb = (n == q) ? cur : store_mem[n % ring];
                            if (nb.alpha != 8'd0) begin
                                sum_r += nb.red;
                                sum_g += nb.green;
                                sum_b += nb.blue;
                                cnt++;
                            end
                        end
                    end
                end
                if (cnt != 0) begin
                    res.pix.red   = 8'(sum_r / cnt);
                    res.pix.green = 8'(sum_g / cnt);
                    res.pix.blue  = 8'(sum_b / cnt);
                    res.pix.alpha = DILATED_ALPHA;
                end
            end
        end
        // a pixel arriving after the slice is full counts as drain
        if (q < total)
            store_mem[q % ring] = cur;
        in_count = in_count + 1'b1;
        if (emit) begin
            out_count     = out_count + 1'b1;
            res.frame_end = (out_count == 16'(total));
            if (res.frame_end) begin
                in_count  = '0;
                out_count = '0;
            end
            expected_pixels.insert(expected_pixels.size(), res);
        end
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold when a test asks for one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog. Values are read at the edge, so they
    // are the ones the handshake saw.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual r=%0d g=%0d b=%0d a=%0d end=%0b",
                         $time, o_out_red, o_out_green, o_out_blue, o_out_alpha, o_frame_end);
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_red",   want.pix.red,   o_out_red);
                check_field("out_green", want.pix.green, o_out_green);
                check_field("out_blue",  want.pix.blue,  o_out_blue);
                check_field("out_alpha", want.pix.alpha, o_out_alpha);
                check_field("frame_end", want.frame_end, o_frame_end);
            end
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // One input transfer, with random idle cycles in front of it
    task automatic send_transfer(input t_pixel px, input logic drain);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_red   <= px.red;
        i_in_green <= px.green;
        i_in_blue  <= px.blue;
        i_in_alpha <= px.alpha;
        i_drain    <= drain;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (predict_dilation(px, drain))
            items_taken++;
    endtask

    // Wait until every result is out and the pipe has emptied
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Valid is left high; the caller lowers it after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == REG_SLICE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        // any write restarts the slice
        in_count  = '0;
        out_count = '0;
    endtask

    task automatic set_slice_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        settle_block();
        write_register(REG_SLICE_WIDTH, w);
        write_register(REG_SLICE_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // A random slice for the current size, then its drain transfers.
    // noise_pct mixes in dropped drains and pixels that count as drain;
    // stop_at >= 0 abandons the slice after that many transfers.
    task automatic send_slice(input int opaque_pct, input int noise_pct, input int stop_at);
        int w, total, sent;
        w     = clamp_dim(width_reg, MAX_SLICE_WIDTH_DEF);
        total = w * clamp_dim(height_reg, MAX_SLICE_HEIGHT);
        sent  = 0;
        for (int i = 0; i < total + w + 1; i++) begin
            if (sent == stop_at)
                return;
            if (i < total) begin
                if ($urandom_range(99) < noise_pct)
                    send_transfer(random_pixel(50), 1'b1);
                send_transfer(random_pixel(opaque_pct), 1'b0);
            end else begin
                send_transfer(random_pixel(50), !($urandom_range(99) < noise_pct));
            end
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size is 64x64: part of a slice, with a dropped drain inside it.
    // The next size write abandons it.
    task automatic test_reset_defaults();
        for (int i = 0; i < 70; i++) begin
            if (i == 30)
                send_transfer(random_pixel(50), 1'b1);
            send_transfer(random_pixel(60), 1'b0);
        end
    endtask

    // Hand-built 3x3 windows: corners, edges, extreme colours, dilation with
    // partial neighbourhoods, and the largest possible sum of eight.
    task automatic test_directed_window();
        t_pixel frame3 [9];
        frame3 = '{make_pixel(255, 255, 255, 255), make_pixel(0, 0, 0, 0),
                   make_pixel(255, 0, 128, 1),     make_pixel(10, 20, 30, 255),
                   make_pixel(77, 88, 99, 0),      make_pixel(1, 2, 3, 128),
                   make_pixel(255, 255, 255, 0),   make_pixel(254, 253, 252, 200),
                   make_pixel(0, 0, 0, 255)};
        set_slice_dims(9'd3, 9'd3);
        for (int i = 0; i < 9; i++) begin
            send_transfer(frame3[i], 1'b0);
            if (i == 4)
                send_transfer(make_pixel(1, 2, 3, 4), 1'b1);   // dropped
        end
        // second drain slot carries a pixel, which only counts as drain
        for (int i = 0; i < 4; i++)
            send_transfer(i == 1 ? make_pixel(9, 9, 9, 9) : make_pixel(0, 0, 0, 0), i != 1);

        // transparent centre among eight fully saturated neighbours
        set_slice_dims(9'd3, 9'd3);
        for (int i = 0; i < 9; i++)
            send_transfer(i == 4 ? make_pixel(1, 1, 1, 0) : make_pixel(255, 255, 255, 255),
                          1'b0);
        for (int i = 0; i < 4; i++)
            send_transfer(make_pixel(0, 0, 0, 0), 1'b1);
    endtask

    // Size extremes, including out-of-range register values
    task automatic test_dim_extremes();
        // 0x0 acts as 1x1: a lone transparent pixel passes unchanged
        set_slice_dims(9'd0, 9'd0);
        send_transfer(make_pixel(200, 100, 50, 0), 1'b0);
        send_transfer(make_pixel(0, 0, 0, 0), 1'b1);
        send_transfer(make_pixel(0, 0, 0, 0), 1'b1);

        set_slice_dims(9'd511, 9'd0);   // 256 x 1
        send_slice(50, 0, -1);
        set_slice_dims(9'd0, 9'd511);   // 1 x 256
        send_slice(50, 0, -1);
    endtask

    // Receiver holds off for a long stretch while the sender keeps going,
    // so the block backs up and stalls its input.
    task automatic test_backpressure();
        send_gap_pct = 0;
        rx_stall_pct = 0;
        set_slice_dims(9'd8, 9'd8);
        hold_asked++;
        send_slice(50, 0, -1);
    endtask

    // Random slices under each idling pattern. Mostly small sizes; a few
    // zero-sized ones.
    task automatic test_random_slices();
        int gap_by_phase   [4] = '{0, 80, 0, 20};
        int stall_by_phase [4] = '{0, 0, 80, 20};
        int target, w, h, r, stop;
        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = gap_by_phase[ph];
            rx_stall_pct = stall_by_phase[ph];
            target       = items_taken + 20;
            while (items_taken < target) begin
                r = $urandom_range(99);
                if (r < 5)
                    w = 0;
                else if (r < 85)
                    w = $urandom_range(12, 1);
                else
                    w = $urandom_range(40, 13);
                r = $urandom_range(99);
                if (w > 12)
                    h = $urandom_range(6, 1);
                else if (r < 5)
                    h = 0;
                else if (r < 80)
                    h = $urandom_range(10, 1);
                else
                    h = $urandom_range(20, 11);
                set_slice_dims(9'(w), 9'(h));
                // one slice in ten is abandoned part way
                if ($urandom_range(9) == 0)
                    stop = $urandom_range(clamp_dim(9'(w), MAX_SLICE_WIDTH_DEF) *
                                          (clamp_dim(9'(h), MAX_SLICE_HEIGHT) + 1), 0);
                else
                    stop = -1;
                send_slice($urandom_range(100, 0), ($urandom_range(3) == 0) ? 10 : 0, stop);
            end
        end
        send_gap_pct = 0;
        rx_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_window();
        test_dim_extremes();
        test_backpressure();
        test_random_slices();

        settle_block();
        repeat (16) @(posedge i_clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
